// ===== sv/cofr_pkg.sv =====
// Package for the circle outline and fill rasterizer: operation codes and defaults.
`default_nettype none
package cofr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;

  typedef enum logic [1:0] {
    OP_START_OUTLINE = 2'd0,
    OP_START_FILL    = 2'd1,
    OP_NEXT          = 2'd2
  } cofr_op_t;

endpackage
`default_nettype wire

// ===== sv/cofr_core.sv =====
// Rasterizer core: circle walk state and the result of one request.
`default_nettype none
module cofr_core
  import cofr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned POS_BITS  = COORD_BITS + 2,
  localparam int unsigned LEN_BITS  = COORD_BITS + 1,
  localparam int unsigned RES_BITS  = 2 * POS_BITS + LEN_BITS + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  input  wire logic [1:0]            in_op,
  input  wire logic [COORD_BITS-1:0] in_cx,
  input  wire logic [COORD_BITS-1:0] in_cy,
  input  wire logic [COORD_BITS-1:0] in_radius,
  output logic                       res_push,
  output logic [RES_BITS-1:0]        res_data   // {last, span_length, pos_y, pos_x}
);

  localparam int unsigned DEC_BITS = COORD_BITS + 6;

  logic signed [DEC_BITS-1:0] dec_r, dec_nxt;
  logic [COORD_BITS-1:0]      x_r, x_nxt, y_r, y_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic                       fill_r, fill_nxt, busy_r, busy_nxt;
  logic [2:0]                 idx_r, idx_nxt;

  logic                       zero_case, step_end, done;
  logic [2:0]                 idx_final;
  logic [COORD_BITS-1:0]      mag_x, mag_y, x_adv, y_adv;
  logic                       sub_x, sub_y;
  logic signed [DEC_BITS-1:0] dec_adv, dec_start;
  logic [DEC_BITS-1:0]        x4, y4;
  logic [POS_BITS-1:0]        pos_x, pos_y, cx_ext, cy_ext, mx_ext, my_ext;
  logic [LEN_BITS-1:0]        span_len;

  assign zero_case = (y_r == '0);
  assign x4 = {{(DEC_BITS-COORD_BITS-2){1'b0}}, x_r, 2'b00};
  assign y4 = {{(DEC_BITS-COORD_BITS-2){1'b0}}, y_r, 2'b00};
  assign dec_start = DEC_BITS'(3) - {{(DEC_BITS-COORD_BITS-1){1'b0}}, in_radius, 1'b0};

  // one Bresenham step
  always_comb begin
    if (dec_r[DEC_BITS-1]) begin
      dec_adv = dec_r + signed'(x4) + DEC_BITS'(6);
      y_adv   = y_r;
    end else begin
      dec_adv = dec_r + signed'(x4 - y4) + DEC_BITS'(10);
      y_adv   = y_r - COORD_BITS'(1);
    end
    x_adv = x_r + COORD_BITS'(1);
  end

  // index of the final result of this step
  always_comb begin
    if (!fill_r)          idx_final = 3'd7;
    else if (zero_case)   idx_final = 3'd0;
    else if (x_r != '0)   idx_final = 3'd3;
    else                  idx_final = 3'd1;
  end

  assign step_end = (idx_r == idx_final);
  assign done     = step_end && (zero_case || (x_adv > y_adv));

  // mirrored coordinate selection
  always_comb begin
    if (!fill_r) begin
      mag_x    = idx_r[1] ? y_r : x_r;
      mag_y    = idx_r[1] ? x_r : y_r;
      sub_x    = idx_r[2];
      sub_y    = idx_r[0];
      span_len = LEN_BITS'(1);
    end else begin
      mag_x    = idx_r[1] ? x_r : y_r;
      mag_y    = idx_r[1] ? y_r : x_r;
      sub_x    = 1'b1;
      sub_y    = idx_r[1] ^ idx_r[0];
      span_len = {mag_x, 1'b0};
    end
  end

  assign cx_ext = {2'b00, cx_r};
  assign cy_ext = {2'b00, cy_r};
  assign mx_ext = {2'b00, mag_x};
  assign my_ext = {2'b00, mag_y};
  assign pos_x  = sub_x ? (cx_ext - mx_ext) : (cx_ext + mx_ext);
  assign pos_y  = sub_y ? (cy_ext - my_ext) : (cy_ext + my_ext);

  assign res_data = {done, span_len, pos_y, pos_x};

  always_comb begin
    dec_nxt  = dec_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    fill_nxt = fill_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    res_push = 1'b0;
    if (in_fire) begin
      case (cofr_op_t'(in_op))
        OP_START_OUTLINE, OP_START_FILL: begin
          dec_nxt  = dec_start;
          x_nxt    = '0;
          y_nxt    = in_radius;
          cx_nxt   = in_cx;
          cy_nxt   = in_cy;
          fill_nxt = (cofr_op_t'(in_op) == OP_START_FILL);
          busy_nxt = 1'b1;
          idx_nxt  = '0;
        end
        OP_NEXT: begin
          if (busy_r) begin
            res_push = 1'b1;
            if (step_end) begin
              idx_nxt = '0;
              if (!zero_case) begin
                dec_nxt = dec_adv;
                x_nxt   = x_adv;
                y_nxt   = y_adv;
              end
              if (done) busy_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r  <= '0;
      x_r    <= '0;
      y_r    <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      fill_r <= 1'b0;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      dec_r  <= dec_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cofr_skid.sv =====
// Output register with one skid entry between the core and the result channel.
`default_nettype none
module cofr_skid
  import cofr_pkg::*;
#(
  parameter int unsigned WIDTH = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  output logic                  push_ready,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = out_valid_r;
  assign pop_data   = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop_ready) begin
      // no push can coincide with a held skid entry
      out_valid_nxt  = skid_valid_r || push;
      out_data_nxt   = skid_valid_r ? skid_data_r : push_data;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/circle_outline_fill_rasterizer.sv =====
// Output: each next request taken while a circle is in progress yields one
// result, held in the output register or, while out_ stalls, the skid entry.
// Throughput: one input transfer per cycle while the skid entry is free.
// Reset: synchronous active-low rst_n returns to idle with no circle in progress
// and both output entries empty.
`default_nettype none
module circle_outline_fill_rasterizer
  import cofr_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned POS_BITS  = COORD_BITS + 2,
  localparam int unsigned LEN_BITS  = COORD_BITS + 1,
  localparam int unsigned IN_RAW    = 2 + 3 * COORD_BITS,
  localparam int unsigned IN_BITS   = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW   = 2 * POS_BITS + LEN_BITS,
  localparam int unsigned OUT_BITS  = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // operation, center_x, center_y, radius (lowest bits first), zero pad
  input  wire logic [IN_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // pos_x, pos_y, span_length (lowest bits first), zero pad
  output logic [OUT_BITS-1:0]      out_tdata,
  output logic                     out_tlast
);

  localparam int unsigned RES_BITS = OUT_RAW + 1;

  logic                  in_fire, res_push, push_ready;
  logic [RES_BITS-1:0]   res_data, pop_data;
  logic [IN_BITS-1:0]    in_unused;

  // a transfer is taken whenever the skid entry is free
  assign in_tready = push_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_unused = in_tdata;

  // Core: per-request result and Bresenham step; the circle ends once x passes y or y is zero.
  cofr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_op     (in_unused[1:0]),
    .in_cx     (in_unused[2 +: COORD_BITS]),
    .in_cy     (in_unused[2 + COORD_BITS +: COORD_BITS]),
    .in_radius (in_unused[2 + 2 * COORD_BITS +: COORD_BITS]),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result register plus skid entry keeps input flowing through a one-result output stall.
  cofr_skid #(
    .WIDTH (RES_BITS)
  ) u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ready (push_ready),
    .push       (res_push),
    .push_data  (res_data),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (pop_data)
  );

  assign out_tdata = {{(OUT_BITS-OUT_RAW){1'b0}}, pop_data[OUT_RAW-1:0]};
  assign out_tlast = pop_data[RES_BITS-1];

endmodule
`default_nettype wire
